@@ hdl/bfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned FIELD_W    = 14;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_SHIFT = 5;
  localparam int unsigned BIT_W      = 5;

  localparam logic [FIELD_W-1:0] TOTAL_RESET = 14'd8192;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic step;
    logic eval;
    logic emit;
  } bfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic early;
    logic resolved;
    logic out_free;
  } bfa_sts_t;

endpackage
`default_nettype wire

@@ hdl/bfa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/bfa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: clearing pass, request intake, word scan and result hand-off.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bfa_sts_t sts_i,
  output bfa_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = sts_i.early ? S_DONE : S_FIRST;
      end
      S_FIRST: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.resolved) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_FIRST: begin
        cmd_o.step = 1'b1;
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        cmd_o.eval = 1'b1;
      end
      S_DONE: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/bfa_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_dpath
// Occupancy word memory, word scan with priority encoder, counters and the
// result register.
// ----------------------------------------------------------------------------
module bfa_dpath import bfa_pkg::*; #(
  parameter int unsigned MAP_ENTRIES = 8192
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bfa_cmd_t            cmd_i,
  output bfa_sts_t                 sts_o,
  input  wire logic                cfg_valid_i,
  input  wire logic [FIELD_W-1:0]  cfg_data_i,
  input  wire logic                in_action_i,
  input  wire logic [FIELD_W-1:0]  in_number_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               out_status_o,
  output logic [FIELD_W-1:0]       out_grant_o,
  output logic [FIELD_W-1:0]       out_free_o
);

  localparam int unsigned WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WC_W  = $clog2(WORDS + 1);
  localparam int unsigned CMP_W = (WC_W + WORD_SHIFT > FIELD_W + 1) ?
                                  WC_W + WORD_SHIFT : FIELD_W + 1;
  localparam logic [WC_W-1:0]    LAST_WORD = WC_W'(WORDS - 1);
  localparam logic [FIELD_W-1:0] MAP_CAP   = FIELD_W'(MAP_ENTRIES);

  logic [FIELD_W-1:0] total_q, used_q, num_q;
  action_e            action_q;
  logic [WC_W-1:0]    wptr_q, eval_q;
  status_e            res_status_q;
  logic [FIELD_W-1:0] res_grant_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [FIELD_W-1:0] out_grant_q, out_free_q;

  logic [FIELD_W-1:0]   eff, pos_in, pos_q, grant_num, free_now;
  logic [CMP_W-1:0]     base, eff_ext, rem;
  logic                 past_end, hit, fset;
  logic [WORD_BITS-1:0] rd_data, valid_mask, free_bits, wdata;
  logic [BIT_W-1:0]     hit_idx, fbit;
  logic                 we, alloc_wr, free_wr;
  logic [WIDX-1:0]      waddr;

  // entries beyond the map never exist
  assign eff    = (32'(total_q) > MAP_ENTRIES) ? MAP_CAP : total_q;
  assign pos_in = in_number_i - FIELD_W'(1);
  assign pos_q  = num_q - FIELD_W'(1);

  assign sts_o.early = (in_action_i == ACT_FREE) &&
                       ((in_number_i == '0) || (in_number_i > eff));
  assign sts_o.clr_last = (wptr_q == LAST_WORD);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (wptr_q[WIDX-1:0]),
    .rdata_o (rd_data)
  );

  // bits of the word under evaluation that lie below the effective count
  assign base     = CMP_W'({eval_q, {WORD_SHIFT{1'b0}}});
  assign eff_ext  = CMP_W'(eff);
  assign past_end = (base >= eff_ext);
  assign rem      = eff_ext - base;

  always_comb begin
    if (rem >= CMP_W'(WORD_BITS)) begin
      valid_mask = '1;
    end else begin
      valid_mask = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
    end
  end

  assign free_bits = ~rd_data & valid_mask;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit     = 1'b1;
        hit_idx = BIT_W'(i);
      end
    end
  end

  assign grant_num = FIELD_W'({eval_q, hit_idx}) + FIELD_W'(1);
  assign fbit      = pos_q[BIT_W-1:0];
  assign fset      = rd_data[fbit];

  assign alloc_wr = cmd_i.eval && (action_q == ACT_ALLOC) && !past_end && hit;
  assign free_wr  = cmd_i.eval && (action_q == ACT_FREE) && fset;
  assign sts_o.resolved = (action_q == ACT_FREE) || past_end || hit;

  always_comb begin
    we    = cmd_i.clr_step || alloc_wr || free_wr;
    waddr = cmd_i.clr_step ? wptr_q[WIDX-1:0] : eval_q[WIDX-1:0];
    if (cmd_i.clr_step) begin
      wdata = '0;
    end else if (action_q == ACT_ALLOC) begin
      wdata = rd_data | (WORD_BITS'(1) << hit_idx);
    end else begin
      wdata = rd_data & ~(WORD_BITS'(1) << fbit);
    end
  end

  assign free_now = (eff > used_q) ? (eff - used_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RESET;
      used_q      <= '0;
      wptr_q      <= '0;
      eval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        wptr_q <= wptr_q + WC_W'(1);
      end else if (cmd_i.accept) begin
        if (in_action_i == ACT_FREE) begin
          wptr_q <= WC_W'(pos_in >> WORD_SHIFT);
        end else begin
          wptr_q <= '0;
        end
      end else if (cmd_i.step) begin
        eval_q <= wptr_q;
        wptr_q <= wptr_q + WC_W'(1);
      end
      if (alloc_wr) begin
        used_q <= used_q + FIELD_W'(1);
      end else if (free_wr && (used_q != '0)) begin
        used_q <= used_q - FIELD_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q     <= action_e'(in_action_i);
      num_q        <= in_number_i;
      res_status_q <= ST_RANGE;
      res_grant_q  <= '0;
    end else if (cmd_i.eval) begin
      res_grant_q <= '0;
      if (action_q == ACT_ALLOC) begin
        if (alloc_wr) begin
          res_status_q <= ST_OK;
          res_grant_q  <= grant_num;
        end else begin
          res_status_q <= ST_FULL;
        end
      end else begin
        res_status_q <= fset ? ST_OK : ST_ALREADY_FREE;
      end
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
      out_free_q   <= free_now;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_grant_o  = out_grant_q;
  assign out_free_o   = out_free_q;

endmodule
`default_nettype wire

@@ hdl/bitmap_first_free_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over a one-bit-per-entry occupancy map.
// ----------------------------------------------------------------------------
// The map is held as 32-bit words in a RAM of MAP_ENTRIES/32 words, rounded
// up. After reset a clearing pass writes every word to zero; no request is
// taken during it, but the count register can be written. An allocate
// request scans one word per cycle through the RAM read port, from the first
// word until it reaches the word holding the first free entry, or runs past
// the count when the map is full; a free request reads and updates only the
// word holding its entry, and a free with an out-of-range number goes
// straight to the result without reading the map. Waiting for the output
// register to empty delays the next acceptance.
// One request is handled at a time; the next request is taken while the
// previous result still waits in the output register.
module bitmap_first_free_allocator import bfa_pkg::*; #(
  parameter int unsigned MAP_ENTRIES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: total_entries
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [13:0] cfg_data_i,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [13:0] entry_number, [15:14] zero
  input  wire logic        s_axis_tuser,   // [0] action
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [13:0] granted_number, [27:14] free_count
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  bfa_cmd_t           cmd;
  bfa_sts_t           sts;
  logic [FIELD_W-1:0] out_grant, out_free;

  assign cfg_ready_o = 1'b1;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfa_dpath #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_action_i  (s_axis_tuser),
    .in_number_i  (s_axis_tdata[FIELD_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_grant_o  (out_grant),
    .out_free_o   (out_free)
  );

  assign m_axis_tdata = {4'd0, out_free, out_grant};

endmodule
`default_nettype wire

@@ hdl/bfa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a granted number only comes with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[13:0] != 14'd0) |-> m_axis_tuser == ST_OK)
    else $error("grant with failing status");

  // map full never carries a number
  a_full_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[13:0] == 14'd0)
    else $error("map full with nonzero grant");

  // the clearing pass blocks requests right after reset
  a_clear_blocks: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("request taken during clearing pass");

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
